@@ design/context_adaptive_range_encoder_core_macros.svh @@
// assertion macros for the range encoder checker
// used by carc_checker only
`ifndef CONTEXT_ADAPTIVE_RANGE_ENCODER_CORE_MACROS_SVH
`define CONTEXT_ADAPTIVE_RANGE_ENCODER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define CARC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// implication checked also during reset
`define CARC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/carc_pkg.sv @@
// shared types and constants of the context adaptive range encoder
// no dependencies
package carc_pkg;
    localparam int PendBits   = 32;
    localparam int NumCtx     = 48;
    localparam int CntBits    = 17;

    localparam logic [1:0] RegIncr  = 2'd0;
    localparam logic [1:0] RegLimit = 2'd1;
    localparam logic [1:0] RegNear  = 2'd2;
    localparam logic [1:0] RegMid   = 2'd3;

    localparam logic CmdEncode = 1'b0;
    localparam logic CmdFlush  = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_READ  = 10'b0000000010,
        ST_DIV   = 10'b0000000100,
        ST_MUL   = 10'b0000001000,
        ST_NORM  = 10'b0000010000,
        ST_OUT   = 10'b0000100000,
        ST_UPD   = 10'b0001000000,
        ST_FLUSH = 10'b0010000000,
        ST_CLEAR = 10'b0100000000,
        ST_BAD   = 10'b1000000000
    } state_t;
endpackage

@@ design/context_adaptive_range_encoder_core.sv @@
// context adaptive range encoder, top level
// depends on carc_pkg
//
//  channel | dir | contents
//  s_      | in  | tdata {preceding, position, observed, reference, command}
//  m_      | out | tdata {filler_count, filler_byte, head_byte}, tuser, tlast
//  cfg_    | in  | register index and write data
//
// an encode runs a restoring divider of width by total, then at most 3 shift steps
// a flush takes five shift steps plus a clearing pass over all 48 table rows
// reset also runs the clearing pass over all 48 table rows before s_tready rises
// each output beat waits in the output register until taken, stalling the shift steps
module context_adaptive_range_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command, reference_base, observed_base, read_position, preceding_base
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // head_byte, filler_byte, filler_count
    output logic [47:0] m_tdata,
    // bad_symbol
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import carc_pkg::*;

    // configuration registers
    logic [7:0]  incr_reg;
    logic [16:0] limit_reg;
    logic [7:0]  near_reg, mid_reg;

    // coder state
    state_t               state_reg;
    logic [32:0]          low_reg;
    logic [31:0]          width_reg;
    logic [7:0]           cache_reg;
    logic [PendBits-1:0]  pend_reg;

    // context count memory, three counts per row
    logic [3*CntBits-1:0] mem [NumCtx];
    logic [3*CntBits-1:0] row_reg;
    logic [5:0]           ctx_reg;
    logic [5:0]           clr_reg;

    // item registers
    logic [1:0]  refb_reg, obsb_reg, prev_reg;
    logic [7:0]  pos_reg;
    logic [1:0]  k_reg;
    logic [2:0]  shifts_reg;   // flush steps left

    // divider and multiplier shared datapath
    logic [31:0] quo_reg;
    logic [17:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [CntBits+1:0] tot_reg;
    logic [CntBits-1:0] cum_reg;
    logic [CntBits-1:0] fk_reg;

    // output register
    logic        ovalid_reg;
    logic [7:0]  ohead_reg, ofill_reg;
    logic [31:0] ocnt_reg;
    logic        olast_reg, obad_reg;

    logic [CntBits-1:0] f0, f1, f2;
    assign f0 = row_reg[CntBits-1:0];
    assign f1 = row_reg[2*CntBits-1:CntBits];
    assign f2 = row_reg[3*CntBits-1:2*CntBits];

    assign s_tready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign cfg_ready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {ocnt_reg, ofill_reg, ohead_reg};
    assign m_tuser   = obad_reg;
    assign m_tlast   = olast_reg;

    // shift step decisions
    logic        carry;
    logic [31:0] low32;
    logic        release_byte;
    assign carry        = low_reg[32];
    assign low32        = low_reg[31:0];
    assign release_byte = carry || (low32 < 32'hFF00_0000);

    // another byte of this symbol follows if a later shift step sees a top byte below 0xff
    logic more_release;
    assign more_release = (width_reg < 32'h0100_0000)
                          && ((low32[23:16] != 8'hFF)
                              || ((width_reg < 32'h0001_0000)
                                  && ((low32[15:8] != 8'hFF)
                                      || ((width_reg < 32'h0000_0100)
                                          && (low32[7:0] != 8'hFF)))));

    // output register loading
    logic out_free;
    logic load_beat;
    assign out_free  = !ovalid_reg || m_tready;
    assign load_beat = (state_reg == ST_BAD)
                       || (((state_reg == ST_OUT) || (state_reg == ST_FLUSH))
                           && out_free && release_byte);

    // context selection
    logic [1:0] bucket;
    logic [5:0] ctx;
    always_comb begin
        if (pos_reg < near_reg)     bucket = 2'd0;
        else if (pos_reg < mid_reg) bucket = 2'd1;
        else                        bucket = 2'd2;
        ctx = 6'(({4'd0, refb_reg} * 6'd3 + {4'd0, bucket}) * 6'd4 + {4'd0, prev_reg});
    end

    // restoring divider step, dividend bits taken msb first
    logic [4:0]  bit_idx;
    logic [19:0] trial;
    assign bit_idx = 5'(6'd32 - cnt_reg);
    assign trial   = {1'b0, rem_reg, width_reg[bit_idx]} - {1'b0, tot_reg};

    // count update
    logic [CntBits:0]   nf0, nf1, nf2;
    logic [CntBits+1:0] newtot;
    always_comb begin
        nf0 = {1'b0, f0};
        nf1 = {1'b0, f1};
        nf2 = {1'b0, f2};
        case (k_reg)
            2'd0:    nf0 = nf0 + {10'd0, incr_reg};
            2'd1:    nf1 = nf1 + {10'd0, incr_reg};
            default: nf2 = nf2 + {10'd0, incr_reg};
        endcase
        newtot = tot_reg + {11'd0, incr_reg};
        if (newtot > {2'd0, limit_reg}) begin
            nf0 = (nf0 >> 1) | 18'd1;
            nf1 = (nf1 >> 1) | 18'd1;
            nf2 = (nf2 >> 1) | 18'd1;
        end
    end

    logic [48:0] prod;
    logic [48:0] cprod;
    assign prod  = {17'd0, quo_reg} * {32'd0, fk_reg};
    assign cprod = {17'd0, quo_reg} * {32'd0, cum_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR)
            mem[clr_reg] <= {3{17'd1}};
        else if (state_reg == ST_UPD)
            mem[ctx_reg] <= {nf2[CntBits-1:0], nf1[CntBits-1:0], nf0[CntBits-1:0]};
        row_reg <= mem[ctx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            incr_reg     <= 8'd8;
            limit_reg    <= 17'd65536;
            near_reg     <= 8'd50;
            mid_reg      <= 8'd100;
            low_reg      <= '0;
            width_reg    <= 32'hFFFF_FFFF;
            cache_reg    <= '0;
            pend_reg     <= PendBits'(1);
            ovalid_reg   <= 1'b0;
        end else begin
            if (load_beat) ovalid_reg <= 1'b1;
            else if (m_tvalid && m_tready) ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    RegIncr:  incr_reg  <= cfg_data[7:0];
                    RegLimit: limit_reg <= cfg_data;
                    RegNear:  near_reg  <= cfg_data[7:0];
                    RegMid:   mid_reg   <= cfg_data[7:0];
                    default:  ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        refb_reg <= s_tdata[2:1];
                        obsb_reg <= s_tdata[4:3];
                        pos_reg  <= s_tdata[12:5];
                        prev_reg <= s_tdata[14:13];
                        if (s_tdata[0] == CmdFlush) begin
                            shifts_reg   <= 3'd5;
                            state_reg    <= ST_FLUSH;
                        end else if (s_tdata[2:1] == s_tdata[4:3])
                            state_reg <= ST_BAD;
                        else
                            state_reg <= ST_READ;
                    end
                end
                ST_BAD: begin
                    ohead_reg <= '0; ofill_reg <= '0; ocnt_reg <= '0;
                    obad_reg <= 1'b1; olast_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_READ: begin
                    // row_reg is loaded with the context row at this edge
                    ctx_reg   <= ctx;
                    k_reg     <= (refb_reg < obsb_reg) ? obsb_reg - 2'd1 : obsb_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == 6'd0) begin
                        tot_reg <= {2'd0, f0} + {2'd0, f1} + {2'd0, f2};
                        case (k_reg)
                            2'd0:    begin cum_reg <= '0; fk_reg <= f0; end
                            2'd1:    begin cum_reg <= f0; fk_reg <= f1; end
                            default: begin cum_reg <= f0 + f1; fk_reg <= f2; end
                        endcase
                        cnt_reg <= 6'd1;
                        rem_reg <= '0;
                    end else begin
                        if (trial[19]) begin
                            rem_reg <= {rem_reg[16:0], width_reg[bit_idx]};
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end else begin
                            rem_reg <= trial[17:0];
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        if (cnt_reg == 6'd32) state_reg <= ST_MUL;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_MUL: begin
                    // cum * step stays below width, width = step * f[k]
                    low_reg   <= low_reg + {1'b0, cprod[31:0]};
                    width_reg <= prod[31:0];
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    if (width_reg < 32'h0100_0000) begin
                        width_reg <= width_reg << 8;
                        state_reg <= ST_OUT;
                    end else
                        state_reg <= ST_UPD;
                end
                ST_OUT, ST_FLUSH: begin
                    if (out_free) begin
                        if (release_byte) begin
                            ohead_reg  <= cache_reg + {7'd0, carry};
                            ofill_reg  <= carry ? 8'h00 : 8'hFF;
                            ocnt_reg   <= (pend_reg == '0) ? 32'd0 : 32'(pend_reg - 1'b1);
                            obad_reg   <= 1'b0;
                            olast_reg  <= (state_reg == ST_FLUSH) ? (shifts_reg == 3'd1)
                                                                  : !more_release;
                        end
                        if ((state_reg == ST_FLUSH) && (shifts_reg == 3'd1)) begin
                            // final flush step, coder back to its reset values
                            low_reg   <= '0;
                            width_reg <= 32'hFFFF_FFFF;
                            cache_reg <= '0;
                            pend_reg  <= PendBits'(1);
                            clr_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end else begin
                            low_reg <= {1'b0, low32[23:0], 8'd0};
                            if (release_byte) begin
                                cache_reg <= low32[31:24];
                                pend_reg  <= PendBits'(1);
                            end else if (pend_reg != '1)
                                pend_reg <= pend_reg + 1'b1;
                            if (state_reg == ST_FLUSH)
                                shifts_reg <= shifts_reg - 3'd1;
                            else
                                state_reg <= ST_NORM;
                        end
                    end
                end
                ST_UPD: begin
                    // counts written back this cycle
                    state_reg <= ST_IDLE;
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 6'd1;
                    if (clr_reg == 6'(NumCtx - 1))
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ design/carc_checker.sv @@
// port level checker for the range encoder, bound to the top level
// depends on carc_pkg and the macros header
`include "context_adaptive_range_encoder_core_macros.svh"
module carc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import carc_pkg::*;
    `CARC_ASSERT(p_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat dropped")
    `CARC_ASSERT(p_bad, aclk, aresetn,
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0, "bad beat malformed")
    `CARC_ASSERT(p_busy, aclk, aresetn,
        s_tvalid && s_tready |=> !s_tready, "accepted while busy")
    `CARC_ASSERT_ALWAYS(p_rst, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule

bind context_adaptive_range_encoder_core carc_checker u_carc_checker (.*);

@@ tb/tb_context_adaptive_range_encoder_core.sv @@
// self-checking testbench for context_adaptive_range_encoder_core
// depends on carc_pkg and the encoder rtl; predicts every output beat in place
`timescale 1ns / 100ps

module tb_context_adaptive_range_encoder_core;
    import carc_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic [1:0] refb;
        logic [1:0] obsb;
        logic [7:0] pos;
        logic [1:0] prev;
    } sym_t;

    typedef struct packed {
        logic [7:0]  head;
        logic [7:0]  fill;
        logic [31:0] cnt;
        logic        last;
        logic        bad;
    } byte_run_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic        in_taken = 1'b0;

    context_adaptive_range_encoder_core dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // shadow of the encoder state
    logic [7:0]  incr_r;
    logic [16:0] limit_r;
    logic [7:0]  near_r, mid_r;
    logic [32:0] low_q;
    logic [31:0] width_q;
    logic [7:0]  cache_q;
    logic [31:0] pend_q;
    logic [16:0] freq_q [NumCtx][3];

    sym_t      sym_queue [$];
    byte_run_t run_queue [$];
    int        errors = 0;
    int        sender_idle = 20, receiver_idle = 56;
    longint    cycles = 0;

    function automatic byte_run_t mk_run(logic [7:0] h, logic [7:0] f, logic [31:0] c,
                                         logic b);
        byte_run_t r;
        r.head = h; r.fill = f; r.cnt = c; r.last = 1'b0; r.bad = b;
        return r;
    endfunction

    task automatic queue_run(byte_run_t r);
        run_queue.insert(run_queue.size(), r);
    endtask

    task automatic queue_sym(sym_t s);
        sym_queue.insert(sym_queue.size(), s);
    endtask

    task automatic clear_coder();
        low_q = '0; width_q = 32'hFFFF_FFFF; cache_q = '0; pend_q = 32'd1;
        for (int c = 0; c < NumCtx; c++)
            for (int j = 0; j < 3; j++) freq_q[c][j] = 17'd1;
    endtask

    // one byte release step, may append a run
    task automatic release_byte(inout int n);
        logic carry;
        logic [31:0] low32;
        carry = low_q[32];
        low32 = low_q[31:0];
        if (carry || low32 < 32'hFF00_0000) begin
            queue_run(mk_run(cache_q + carry, carry ? 8'h00 : 8'hFF,
                             pend_q == 0 ? 32'd0 : pend_q - 1, 1'b0));
            n++;
            cache_q = low32[31:24];
            pend_q = 0;
        end
        if (pend_q != 32'hFFFF_FFFF) pend_q++;
        low_q = {1'b0, low32[23:0], 8'h00};
    endtask

    task automatic predict_symbol(sym_t s);
        int n;
        int unsigned bucket, ctx, k, tot, cum, step, nt;
        n = 0;
        if (s.cmd == CmdFlush) begin
            for (int i = 0; i < 5; i++) release_byte(n);
            clear_coder();
        end else if (s.obsb == s.refb) begin
            queue_run(mk_run(8'h00, 8'h00, 32'd0, 1'b1));
            n = 1;
        end else begin
            bucket = s.pos < near_r ? 0 : (s.pos < mid_r ? 1 : 2);
            ctx = (s.refb * 3 + bucket) * 4 + s.prev;
            k = s.refb < s.obsb ? s.obsb - 1 : s.obsb;
            tot = freq_q[ctx][0] + freq_q[ctx][1] + freq_q[ctx][2];
            cum = 0;
            for (int j = 0; j < k; j++) cum += freq_q[ctx][j];
            step = width_q / tot;
            low_q = low_q + 33'(64'(cum) * 64'(step));
            width_q = step * freq_q[ctx][k];
            while (width_q < 32'h0100_0000) begin
                width_q = width_q << 8;
                release_byte(n);
            end
            nt = freq_q[ctx][k] + incr_r;
            freq_q[ctx][k] = nt[16:0];
            if (tot + incr_r > limit_r)
                for (int j = 0; j < 3; j++)
                    freq_q[ctx][j] = (freq_q[ctx][j] >> 1) | 17'd1;
        end
        if (n > 0) run_queue[$].last = 1'b1;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            RegIncr:  incr_r  = val[7:0];
            RegLimit: limit_r = val;
            RegNear:  near_r  = val[7:0];
            default:  mid_r   = val[7:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sym_t rand_symbol(bit allow_bad);
        sym_t s;
        s.cmd = ($urandom_range(0, 29) == 0) ? CmdFlush : CmdEncode;
        s.refb = $urandom_range(0, 3);
        s.obsb = $urandom_range(0, 3);
        if (!allow_bad || $urandom_range(0, 19) != 0)
            while (s.obsb == s.refb) s.obsb = $urandom_range(0, 3);
        s.pos = $urandom_range(0, 255);
        s.prev = $urandom_range(0, 3);
        return s;
    endfunction

    function automatic sym_t mk_sym(logic c, logic [1:0] r, logic [1:0] o, logic [7:0] p,
                                    logic [1:0] pr);
        sym_t s;
        s.cmd = c; s.refb = r; s.obsb = o; s.pos = p; s.prev = pr;
        return s;
    endfunction

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (sym_queue.size() != 0 || run_queue.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // input driver: a new beat once the previous one was taken, random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (sym_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, sym_queue[0].prev, sym_queue[0].pos, sym_queue[0].obsb,
                            sym_queue[0].refb, sym_queue[0].cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (aresetn) m_tready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // prediction on every accepted input beat
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_symbol(sym_queue[0]);
            void'(sym_queue.pop_front());
        end
    end

    // output monitor
    always @(posedge aclk) begin
        byte_run_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tlast, m_tuser[0]};
            if (run_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", got);
            end else begin
                want = run_queue.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: head %h/%h fill %h/%h cnt %0d/%0d last %b/%b bad %b/%b",
                                 want.head, got.head, want.fill, got.fill, want.cnt, got.cnt,
                                 want.last, got.last, want.bad, got.bad);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        incr_r = 8; limit_r = 17'd65536; near_r = 50; mid_r = 100;
        clear_coder();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, bad symbol, flush, every base pair
        for (int r = 0; r < 4; r++)
            for (int o = 0; o < 4; o++)
                queue_sym(mk_sym(CmdEncode, r, o, (r * 85) & 8'hFF, 3 - r));
        queue_sym(mk_sym(CmdEncode, 0, 3, 8'd255, 2'd3));
        queue_sym(mk_sym(CmdEncode, 3, 0, 8'd0, 2'd0));
        queue_sym(mk_sym(CmdEncode, 1, 2, 8'd49, 2'd1));
        queue_sym(mk_sym(CmdEncode, 1, 2, 8'd50, 2'd1));
        queue_sym(mk_sym(CmdEncode, 2, 1, 8'd99, 2'd2));
        queue_sym(mk_sym(CmdEncode, 2, 1, 8'd100, 2'd2));
        queue_sym(mk_sym(CmdFlush, 3, 3, 8'hFF, 2'd3));
        drain();

        // several register settings, extremes included, random symbols between them
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(RegIncr, 17'd255); write_reg(RegLimit, 17'd3);
                         write_reg(RegNear, 17'd0); write_reg(RegMid, 17'd0); end
                1: begin write_reg(RegIncr, 17'd1); write_reg(RegLimit, 17'd65536);
                         write_reg(RegNear, 17'd255); write_reg(RegMid, 17'd255); end
                2: begin write_reg(RegIncr, 17'd0); write_reg(RegLimit, 17'd0);
                         write_reg(RegNear, 17'd200); write_reg(RegMid, 17'd30); end
                3: begin write_reg(RegIncr, 17'd200); write_reg(RegLimit, 17'h1FFFF);
                         write_reg(RegNear, 17'd60); write_reg(RegMid, 17'd180); end
                4: begin write_reg(RegIncr, 17'd32); write_reg(RegLimit, 17'd1000);
                         write_reg(RegNear, 17'd50); write_reg(RegMid, 17'd100); end
                default: begin write_reg(RegIncr, 17'd8); write_reg(RegLimit, 17'd65536); end
            endcase
            if (phase == 2) begin sender_idle = 56; receiver_idle = 20; end
            if (phase == 4) begin sender_idle = 0; receiver_idle = 0; end
            for (int i = 0; i < 75; i++) queue_sym(rand_symbol(1'b1));
            drain();
        end

        if (errors == 0 && run_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
